// File: rtl/nbm_pkg.sv
// Shared types and constants for the nibble bank mapper with IRQ counter.
`default_nettype none
package nbm_pkg;

	typedef enum logic [1:0] {
		CMD_WRITE  = 2'd0,
		CMD_TICK   = 2'd1,
		CMD_LOOKUP = 2'd2,
		CMD_NOP    = 2'd3
	} cmd_t;

	// Register decode of the IRQ and mirroring window (address & IRQ_DECODE_MASK)
	localparam logic [15:0] IRQ_DECODE_MASK = 16'hF003;
	localparam logic [15:0] REG_RELOAD_N0   = 16'hE000;
	localparam logic [15:0] REG_RELOAD_N1   = 16'hE001;
	localparam logic [15:0] REG_RELOAD_N2   = 16'hE002;
	localparam logic [15:0] REG_RELOAD_N3   = 16'hE003;
	localparam logic [15:0] REG_COUNTER_LD  = 16'hF000;
	localparam logic [15:0] REG_IRQ_CTRL    = 16'hF001;
	localparam logic [15:0] REG_MIRROR      = 16'hF002;

	// Window bases
	localparam logic [15:0] PRG_BASE   = 16'h8000;
	localparam logic [15:0] CHR_BASE   = 16'hA000;
	localparam logic [15:0] CTRL_BASE  = 16'hE000;
	localparam logic [15:0] WRAM_BASE  = 16'h6000;
	localparam logic [15:0] CHR_LIMIT  = 16'h2000;
	localparam logic [7:0]  FIXED_BANK = 8'hFF;

	localparam int PRG_BANKS = 4;
	localparam int CHR_BANKS = 8;

	// Program bank reset values, entry 0 in the low byte
	localparam logic [PRG_BANKS-1:0][7:0] PRG_RESET = {8'hFF, 8'hFE, 8'h01, 8'h00};

	typedef logic [PRG_BANKS-1:0][7:0] prg_banks_t;
	typedef logic [CHR_BANKS-1:0][7:0] chr_banks_t;

	// Replace one nibble of a bank register: odd address sets the high nibble
	function automatic logic [7:0] set_nibble(input logic [7:0] old, input logic odd,
		input logic [3:0] val);
		set_nibble = odd ? {val, old[3:0]} : {old[7:4], val};
	endfunction

endpackage
`default_nettype wire

// File: rtl/nibble_bank_mapper_with_irq_counter_unit.sv
// Nibble bank mapper with 16-bit cycle IRQ counter: top level.
// An accepted input transaction is registered in the input stage, then in the result reg.
// Throughput: one transaction per clock; a new one is taken while a result waits in the
//   output register, so only a stalled output holds off the input.
// Reset (arst_n low, asynchronous): program banks 0,1,FE,FF, pattern banks, IRQ state and
//   mirroring cleared, both pipeline stages empty.
`default_nettype none
module nibble_bank_mapper_with_irq_counter_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input channel
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  cmd,
	input  wire logic [15:0] address,
	input  wire logic [7:0]  write_value,
	input  wire logic [7:0]  elapsed_cycles,
	input  wire logic        pattern_space,
	// result channel
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             irq_line,
	output logic [7:0]       bank_number,
	output logic             hits_work_ram,
	output logic             mapped,
	output logic [1:0]       mirroring
);

	// ---------------------------------------------------------------
	// Input stage
	// ---------------------------------------------------------------
	logic                 valid_s1;
	nbm_pkg::cmd_t        cmd_s1;
	logic [15:0]          addr_s1;
	logic [3:0]           val_s1;    // only the low nibble (and bits of it) is ever used
	logic [7:0]           cyc_s1;
	logic                 pat_s1;

	logic                 out_free;  // result register empty or being drained
	logic                 advance;   // s1 transaction is executed this cycle

	assign out_free = !out_valid || !out_stall;
	assign advance  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			cmd_s1  <= nbm_pkg::cmd_t'(cmd);
			addr_s1 <= address;
			val_s1  <= write_value[3:0];
			cyc_s1  <= elapsed_cycles;
			pat_s1  <= pattern_space;
		end
	end

	// ---------------------------------------------------------------
	// Mapper state
	// ---------------------------------------------------------------
	nbm_pkg::prg_banks_t  prg_q, prg_d;
	nbm_pkg::chr_banks_t  chr_q, chr_d;
	logic [15:0]          reload_q, reload_d;
	logic [15:0]          counter_q, counter_d;
	logic                 enabled_q, enabled_d;
	logic                 pending_q, pending_d;
	logic [1:0]           mirror_q, mirror_d;

	// Write decode: register index = addr[1] OR'd into (offset >> 11)
	logic [15:0]          prg_off;
	logic [15:0]          chr_off;
	logic [1:0]           prg_widx;
	logic [2:0]           chr_widx;
	logic [15:0]          irq_reg;
	logic                 tick_fires;

	assign prg_off  = addr_s1 - nbm_pkg::PRG_BASE;
	assign chr_off  = addr_s1 - nbm_pkg::CHR_BASE;
	assign prg_widx = prg_off[12:11] | {1'b0, addr_s1[1]};
	assign chr_widx = chr_off[13:11] | {2'b00, addr_s1[1]};
	assign irq_reg  = addr_s1 & nbm_pkg::IRQ_DECODE_MASK;
	// counter expires when the elapsed count reaches or passes it
	assign tick_fires = {8'h00, cyc_s1} >= counter_q;

	always_comb begin
		prg_d     = prg_q;
		chr_d     = chr_q;
		reload_d  = reload_q;
		counter_d = counter_q;
		enabled_d = enabled_q;
		pending_d = pending_q;
		mirror_d  = mirror_q;
		case (cmd_s1)
			nbm_pkg::CMD_WRITE: begin
				if (addr_s1 >= nbm_pkg::CTRL_BASE) begin
					case (irq_reg)
						nbm_pkg::REG_RELOAD_N0: reload_d[3:0]   = val_s1;
						nbm_pkg::REG_RELOAD_N1: reload_d[7:4]   = val_s1;
						nbm_pkg::REG_RELOAD_N2: reload_d[11:8]  = val_s1;
						nbm_pkg::REG_RELOAD_N3: reload_d[15:12] = val_s1;
						nbm_pkg::REG_COUNTER_LD: counter_d = reload_q;
						nbm_pkg::REG_IRQ_CTRL: begin
							enabled_d = val_s1[0];
							pending_d = 1'b0;
						end
						nbm_pkg::REG_MIRROR: mirror_d = val_s1[1:0];
						default: ;
					endcase
				end else if (addr_s1 >= nbm_pkg::CHR_BASE) begin
					chr_d[chr_widx] = nbm_pkg::set_nibble(chr_q[chr_widx], addr_s1[0], val_s1);
				end else if (addr_s1 >= nbm_pkg::PRG_BASE) begin
					prg_d[prg_widx] = nbm_pkg::set_nibble(prg_q[prg_widx], addr_s1[0], val_s1);
				end
			end
			nbm_pkg::CMD_TICK: begin
				// runs only while enabled and not yet at zero
				if (enabled_q && (counter_q != 16'h0000)) begin
					if (tick_fires) begin
						counter_d = 16'h0000;
						pending_d = 1'b1;
						enabled_d = 1'b0;
					end else begin
						counter_d = counter_q - {8'h00, cyc_s1};
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prg_q     <= nbm_pkg::PRG_RESET;
			chr_q     <= '0;
			reload_q  <= '0;
			counter_q <= '0;
			enabled_q <= 1'b0;
			pending_q <= 1'b0;
			mirror_q  <= 2'b00;
		end else if (advance) begin
			prg_q     <= prg_d;
			chr_q     <= chr_d;
			reload_q  <= reload_d;
			counter_q <= counter_d;
			enabled_q <= enabled_d;
			pending_q <= pending_d;
			mirror_q  <= mirror_d;
		end
	end

	// ---------------------------------------------------------------
	// Lookup (reads banks; lookups never change them)
	// ---------------------------------------------------------------
	logic [7:0] bank_d;
	logic       wram_d;
	logic       mapped_d;

	always_comb begin
		bank_d   = 8'h00;
		wram_d   = 1'b0;
		mapped_d = 1'b0;
		if (cmd_s1 == nbm_pkg::CMD_LOOKUP) begin
			if (pat_s1) begin
				if (addr_s1 < nbm_pkg::CHR_LIMIT) begin
					bank_d   = chr_q[addr_s1[12:10]];
					mapped_d = 1'b1;
				end
			end else if (addr_s1 >= nbm_pkg::PRG_BASE) begin
				mapped_d = 1'b1;
				// top 8KB window is hardwired to the last bank
				bank_d = (addr_s1 >= nbm_pkg::CTRL_BASE) ? nbm_pkg::FIXED_BANK
					: prg_q[addr_s1[14:13]];
			end else if (addr_s1 >= nbm_pkg::WRAM_BASE) begin
				wram_d = 1'b1;
			end
		end
	end

	// ---------------------------------------------------------------
	// Result register: status reflects state after this transaction
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_free) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			irq_line      <= pending_d;
			bank_number   <= bank_d;
			hits_work_ram <= wram_d;
			mapped        <= mapped_d;
			// mode 3 behaves as single screen lower
			mirroring     <= mirror_d[1] ? 2'd2 : {1'b0, mirror_d[0]};
		end
	end

`ifndef SYNTHESIS
	// a pending IRQ always leaves the counter disabled
	a_pend_disables: assert property (@(posedge clk) disable iff (!arst_n)
		!(pending_q && enabled_q))
		else $error("IRQ pending while counter still enabled");

	// IRQ only rises out of a tick that drove the counter to zero
	a_rise_at_zero: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(pending_q) |-> (counter_q == 16'h0000) && $past(cmd_s1 == nbm_pkg::CMD_TICK))
		else $error("IRQ raised without counter expiry");

	// input is held off only when a transaction is waiting on a full result register
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid && out_stall)
		else $error("input stalled without backpressure");

	// a result never reports both work RAM and a banked window, nor mirroring mode 3
	a_result_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(hits_work_ram && mapped) && (mirroring != 2'd3))
		else $error("inconsistent result fields");
`endif

endmodule
`default_nettype wire
